// File: src/adsb_preamble_bit_demodulator_assert.svh
// ----------------------------------------------------------------------------
// ADS-B demodulator assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ADSB_PREAMBLE_BIT_DEMODULATOR_ASSERT_SVH
`define ADSB_PREAMBLE_BIT_DEMODULATOR_ASSERT_SVH

// Same-cycle implication
`define ABD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ABD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg
// Types and constants shared by the ADS-B preamble and bit demodulator.
// ----------------------------------------------------------------------------
package abd_pkg;

    localparam int MAX_SLOTS    = 32;
    localparam int MESSAGE_BITS = 112;

    localparam int WIN_LEN    = 18;
    localparam int HALF_BITS  = 56;
    localparam int BITS_W     = 2 * HALF_BITS;
    localparam int SAMPLE_W   = 8;
    localparam int POWER_W    = 16;
    localparam int AMP_W      = POWER_W + 1;
    localparam int SUM_W      = 22;
    localparam int POS_W      = 40;
    localparam int FILL_W     = 5;
    localparam int CNT_W      = $clog2(MESSAGE_BITS + 1);
    localparam int SLOT_IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_i;
        logic [SAMPLE_W-1:0] sample_q;
    } in_t;

    typedef struct packed {
        logic [HALF_BITS-1:0] bits_first_half;
        logic [HALF_BITS-1:0] bits_second_half;
        logic [SUM_W-1:0]     amplitude_sum;
        logic [POS_W-1:0]     start_position;
    } out_t;

    // One message slot as held in the slot memory
    typedef struct packed {
        logic              phase;
        logic [CNT_W-1:0]  bit_count;
        logic [BITS_W-1:0] bits;
        logic [SUM_W-1:0]  amp_sum;
        logic [POS_W-1:0]  start;
    } slot_t;

    // Window status from the front end to the slot engine
    typedef struct packed {
        logic             win_full;
        logic             preamble;
        logic             data_bit;
        logic [AMP_W-1:0] amp;
        logic [POS_W-1:0] position;
    } front_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

// File: src/abd_ram.sv
// ----------------------------------------------------------------------------
// abd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module abd_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/abd_front.sv
// ----------------------------------------------------------------------------
// abd_front
// Sample power, 18-deep power window, preamble test and bit decision.
// ----------------------------------------------------------------------------
module abd_front
    import abd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   accept,
    input  in_t    sample,
    input  logic   step_done,
    output front_t status
);

    localparam logic signed [SAMPLE_W:0] OFFSET = (SAMPLE_W + 1)'(128);

    logic signed [SAMPLE_W:0]     di;
    logic signed [SAMPLE_W:0]     dq;
    logic signed [2*SAMPLE_W+1:0] sq_i;
    logic signed [2*SAMPLE_W+1:0] sq_q;
    logic [POWER_W-1:0]           power;

    logic [POWER_W-1:0] window_reg [WIN_LEN];
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [POS_W-1:0]   position_reg;
    logic [POS_W-1:0]   position_next;

    // Form the sample power from the centered components
    always_comb begin
        di    = $signed({1'b0, sample.sample_i}) - OFFSET;
        dq    = $signed({1'b0, sample.sample_q}) - OFFSET;
        sq_i  = di * di;
        sq_q  = dq * dq;
        power = sq_i[POWER_W-1:0] + sq_q[POWER_W-1:0];
    end

    // Shift the window on every request
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < WIN_LEN - 1; k++) begin
                window_reg[k] <= window_reg[k+1];
            end
            window_reg[WIN_LEN-1] <= power;
        end
    end

    // Advance fill level and window position
    always_comb begin
        fill_next     = fill_reg;
        position_next = position_reg;
        if (accept && (fill_reg < FILL_W'(WIN_LEN))) begin
            fill_next = fill_reg + 1'b1;
        end
        if (step_done) begin
            position_next = position_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            position_reg <= '0;
        end else begin
            fill_reg     <= fill_next;
            position_reg <= position_next;
        end
    end

    // Preamble pulses and the bit decision on the newest pair
    always_comb begin
        status.win_full = (fill_reg == FILL_W'(WIN_LEN));
        status.preamble = (window_reg[1] < window_reg[0]) &&
                          (window_reg[2] > window_reg[1]) &&
                          (window_reg[3] < window_reg[2]) &&
                          (window_reg[4] < window_reg[0]) &&
                          (window_reg[5] < window_reg[0]) &&
                          (window_reg[6] < window_reg[0]) &&
                          (window_reg[8] < window_reg[7]) &&
                          (window_reg[9] > window_reg[8]);
        status.data_bit = (window_reg[17] <= window_reg[16]);
        status.amp      = {1'b0, window_reg[16]} + {1'b0, window_reg[17]};
        status.position = position_reg;
    end

endmodule

// File: src/abd_slot_engine.sv
// ----------------------------------------------------------------------------
// abd_slot_engine
// Walks the slot memory once per window: claim, feed, complete, write back.
// ----------------------------------------------------------------------------
`include "adsb_preamble_bit_demodulator_assert.svh"

module abd_slot_engine
    import abd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  front_t status,
    input  logic   out_free,
    output logic   idle,
    output logic   step_done,
    output logic   res_load,
    output out_t   res
);

    state_t state_reg;
    state_t state_next;

    logic [SLOT_CNT_W-1:0] rd_cnt_reg;
    logic [SLOT_CNT_W-1:0] rd_cnt_next;
    logic                  wb_pend_reg;
    logic                  wb_pend_next;
    logic [SLOT_IDX_W-1:0] wb_idx_reg;
    logic [SLOT_IDX_W-1:0] wb_idx_next;
    logic [MAX_SLOTS-1:0]  valid_reg;
    logic [MAX_SLOTS-1:0]  valid_next;
    logic                  open_pend_reg;
    logic                  open_pend_next;
    logic                  res_pend_reg;
    logic                  res_pend_next;
    out_t                  res_reg;
    out_t                  res_next;

    logic                  ram_re;
    logic                  ram_we;
    logic [SLOT_IDX_W-1:0] rd_idx;
    slot_t                 ram_rdata;
    slot_t                 fresh;
    slot_t                 cur;
    slot_t                 upd;
    logic                  claim;
    logic                  wb_fire;
    logic                  slot_done;
    logic [BITS_W-1:0]     aligned;

    assign rd_idx = rd_cnt_reg[SLOT_IDX_W-1:0];

    abd_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wb_idx_reg),
        .wdata (upd),
        .re    (ram_re),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // Modify the slot read back last cycle; a free slot may be claimed
    always_comb begin
        fresh         = '0;
        fresh.start   = status.position;
        claim         = open_pend_reg && !valid_reg[wb_idx_reg];
        wb_fire       = (state_reg == ST_WALK) && wb_pend_reg &&
                        (valid_reg[wb_idx_reg] || claim);
        cur           = claim ? fresh : ram_rdata;
        upd           = cur;
        upd.phase     = !cur.phase;
        slot_done     = 1'b0;
        if (upd.phase) begin
            if (cur.bit_count < CNT_W'(HALF_BITS)) begin
                upd.amp_sum = cur.amp_sum + SUM_W'(status.amp);
            end
            upd.bits      = {cur.bits[BITS_W-2:0], status.data_bit};
            upd.bit_count = cur.bit_count + 1'b1;
            slot_done     = (upd.bit_count >= CNT_W'(MESSAGE_BITS));
        end
        aligned = upd.bits << (BITS_W - MESSAGE_BITS);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = status.win_full ? ST_WALK : ST_IDLE;
            end
            ST_WALK: begin
                if ((rd_cnt_reg == SLOT_CNT_W'(MAX_SLOTS)) && !wb_pend_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!res_pend_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and memory strobes
    always_comb begin
        idle      = (state_reg == ST_IDLE);
        ram_re    = (state_reg == ST_WALK) && (rd_cnt_reg < SLOT_CNT_W'(MAX_SLOTS));
        ram_we    = wb_fire;
        step_done = (state_reg == ST_FINISH) && (!res_pend_reg || out_free);
        res_load  = step_done && res_pend_reg;
        res       = res_reg;
    end

    // Walk counters, valid bits and the pending result
    always_comb begin
        rd_cnt_next    = rd_cnt_reg;
        wb_pend_next   = 1'b0;
        wb_idx_next    = wb_idx_reg;
        valid_next     = valid_reg;
        open_pend_next = open_pend_reg;
        res_pend_next  = res_pend_reg;
        res_next       = res_reg;
        if (state_reg == ST_PREP) begin
            rd_cnt_next    = '0;
            open_pend_next = status.preamble;
        end
        if (ram_re) begin
            rd_cnt_next  = rd_cnt_reg + 1'b1;
            wb_pend_next = 1'b1;
            wb_idx_next  = rd_idx;
        end
        if (wb_fire) begin
            if (claim) begin
                valid_next[wb_idx_reg] = 1'b1;
                open_pend_next         = 1'b0;
            end
            if (slot_done) begin
                valid_next[wb_idx_reg] = 1'b0;
                if (!res_pend_reg) begin
                    res_pend_next             = 1'b1;
                    res_next.bits_first_half  = aligned[BITS_W-1 -: HALF_BITS];
                    res_next.bits_second_half = aligned[HALF_BITS-1:0];
                    res_next.amplitude_sum    = upd.amp_sum;
                    res_next.start_position   = upd.start;
                end
            end
        end
        if (step_done) begin
            res_pend_next  = 1'b0;
            open_pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            wb_pend_reg   <= 1'b0;
            valid_reg     <= '0;
            open_pend_reg <= 1'b0;
            res_pend_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            wb_pend_reg   <= wb_pend_next;
            valid_reg     <= valid_next;
            open_pend_reg <= open_pend_next;
            res_pend_reg  <= res_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        wb_idx_reg <= wb_idx_next;
        res_reg    <= res_next;
    end

    // A second completion in one window would lose a message
    `ABD_ASSERT_IMP(a_one_result, wb_fire && slot_done, !res_pend_reg, "two results in one window")
    // The output register must be free when a result moves out
    `ABD_ASSERT_IMP(a_load_free, res_load, out_free, "result loaded over a waiting one")
    // No write-back may be left behind when the walk ends
    `ABD_ASSERT_IMP(a_idle_drained, state_reg != ST_WALK, !wb_pend_reg, "write-back outside walk")
    // A finished window returns to idle
    `ABD_ASSERT_NXT(a_done_idle, step_done, state_reg == ST_IDLE, "step end not followed by idle")

endmodule

// File: src/adsb_preamble_bit_demodulator.sv
// ----------------------------------------------------------------------------
// adsb_preamble_bit_demodulator
// Mode S preamble search and 2-sample-per-bit demodulation of I/Q bytes.
// ----------------------------------------------------------------------------
// A sample request is served by the slot engine walking the slot memory
// one entry per cycle through its single read port; during the first 17
// samples, while the power window fills, the walk is skipped. A decoded
// message is held in the output register, and the next sample is taken
// while it waits. The slot memory is not cleared: slots are tracked by
// valid flags that reset clears at once.
module adsb_preamble_bit_demodulator
    import abd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    front_t status;
    logic   accept;
    logic   idle;
    logic   step_done;
    logic   res_load;
    logic   out_free;
    out_t   res;
    logic   m_valid_reg;
    logic   m_valid_next;
    out_t   m_payload_reg;

    assign s_ready  = idle;
    assign accept   = s_valid && idle;
    assign out_free = !m_valid_reg || m_ready;

    abd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .sample    (s_payload),
        .step_done (step_done),
        .status    (status)
    );

    abd_slot_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .status    (status),
        .out_free  (out_free),
        .idle      (idle),
        .step_done (step_done),
        .res_load  (res_load),
        .res       (res)
    );

    // Hold the result until the downstream request completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_payload_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for adsb_preamble_bit_demodulator
// Streams I/Q byte pairs into the demodulator: extreme values while the
// power window fills, then shaped traffic with clean preambles followed by
// pulse-coded bits, dense preamble bursts that can overflow the slot pool,
// broken preambles and noise. A scoreboard model of the window and the
// slot pool predicts every decoded message, which is checked field by field.
// ----------------------------------------------------------------------------
module testbench
    import abd_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    out_t m_payload;

    // Sample requests waiting to be driven and messages still to come out
    in_t  pending_samples[$];
    out_t expected_msgs[$];

    int   error_count = 0;
    int   samples_taken = 0;
    int   quiet_cycles = 0;
    logic in_taken = 1'b0;
    logic calm;
    out_t want;

    // Scoreboard copy of the demodulator state
    logic [POWER_W-1:0]   pwr_win[WIN_LEN];
    int                   win_count = 0;
    logic [POS_W-1:0]     sample_pos = '0;
    logic                 slot_busy[MAX_SLOTS];
    logic                 slot_odd[MAX_SLOTS];
    int                   slot_nbits[MAX_SLOTS];
    logic [HALF_BITS-1:0] slot_hi[MAX_SLOTS];
    logic [HALF_BITS-1:0] slot_lo[MAX_SLOTS];
    logic [SUM_W-1:0]     slot_amp[MAX_SLOTS];
    logic [POS_W-1:0]     slot_origin[MAX_SLOTS];

    adsb_preamble_bit_demodulator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #1 aclk = ~aclk;

    // No random stalls on either side through the middle of the run
    assign calm = (samples_taken >= 700) && (samples_taken < 1100);

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        $display("MISCOMPARE %s: got %h, exp %h (sample %0d)", what, got, exp_val,
                 samples_taken);
        error_count++;
    endtask

    // Shift one power into the window, run the preamble test and feed the slots
    task automatic decode_sample(input in_t smp);
        int                 di;
        int                 dq;
        int                 k;
        logic [POWER_W-1:0] pw;
        logic [AMP_W-1:0]   amp;
        logic               bit_one;
        logic               opened;
        logic               emitted;
        out_t               msg;
        di = int'(smp.sample_i) - 128;
        dq = int'(smp.sample_q) - 128;
        pw = POWER_W'(di * di + dq * dq);
        for (int j = 0; j < WIN_LEN - 1; j++) pwr_win[j] = pwr_win[j + 1];
        pwr_win[WIN_LEN - 1] = pw;
        if (win_count < WIN_LEN) win_count++;
        if (win_count < WIN_LEN) return;

        // Open the lowest free slot on a preamble, drop it when none is free
        if (pwr_win[1] < pwr_win[0] && pwr_win[2] > pwr_win[1] && pwr_win[3] < pwr_win[2] &&
            pwr_win[4] < pwr_win[0] && pwr_win[5] < pwr_win[0] && pwr_win[6] < pwr_win[0] &&
            pwr_win[8] < pwr_win[7] && pwr_win[9] > pwr_win[8]) begin
            opened = 1'b0;
            for (int s = 0; s < MAX_SLOTS; s++) begin
                if (!opened && !slot_busy[s]) begin
                    slot_busy[s]   = 1'b1;
                    slot_odd[s]    = 1'b0;
                    slot_nbits[s]  = 0;
                    slot_hi[s]     = '0;
                    slot_lo[s]     = '0;
                    slot_amp[s]    = '0;
                    slot_origin[s] = sample_pos;
                    opened = 1'b1;
                end
            end
        end

        amp     = AMP_W'(pwr_win[WIN_LEN - 2]) + AMP_W'(pwr_win[WIN_LEN - 1]);
        bit_one = pwr_win[WIN_LEN - 1] <= pwr_win[WIN_LEN - 2];
        emitted = 1'b0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if (slot_busy[s]) begin
                slot_odd[s] = ~slot_odd[s];
                if (slot_odd[s]) begin
                    k = slot_nbits[s];
                    if (k < HALF_BITS) begin
                        slot_amp[s] = slot_amp[s] + SUM_W'(amp);
                        if (bit_one) slot_hi[s][HALF_BITS - 1 - k] = 1'b1;
                    end else if (k < 2 * HALF_BITS) begin
                        if (bit_one) slot_lo[s][2 * HALF_BITS - 1 - k] = 1'b1;
                    end
                    k++;
                    slot_nbits[s] = k;
                    // Free the slot; emit only the first message of the sample
                    if (k >= MESSAGE_BITS) begin
                        if (!emitted) begin
                            msg.bits_first_half  = slot_hi[s];
                            msg.bits_second_half = slot_lo[s];
                            msg.amplitude_sum    = slot_amp[s];
                            msg.start_position   = slot_origin[s];
                            expected_msgs.push_back(msg);
                        end
                        emitted = 1'b1;
                        slot_busy[s] = 1'b0;
                    end
                end
            end
        end
        sample_pos = sample_pos + 1'b1;
    endtask

    // I/Q pair of power lvl squared, random axis and sign; lvl >= 127 may be (0, 0)
    function automatic in_t level_sample(input int lvl);
        in_t smp;
        int  dev;
        if (lvl >= 127 && $urandom_range(0, 3) == 0) begin
            smp.sample_i = '0;
            smp.sample_q = '0;
        end else begin
            dev = $urandom_range(0, 1) ? lvl : -lvl;
            if ($urandom_range(0, 1)) begin
                smp.sample_i = SAMPLE_W'(128 + dev);
                smp.sample_q = SAMPLE_W'(128);
            end else begin
                smp.sample_i = SAMPLE_W'(128);
                smp.sample_q = SAMPLE_W'(128 + dev);
            end
        end
        return smp;
    endfunction

    // Ten-sample preamble with random levels; a broken one ties one comparison
    task automatic add_preamble(input bit broken);
        int lv[10];
        lv[0] = $urandom_range(64, 127);
        lv[1] = $urandom_range(0, 20);
        lv[2] = $urandom_range(40, 127);
        lv[3] = $urandom_range(0, 20);
        lv[4] = $urandom_range(0, 40);
        lv[5] = $urandom_range(0, 40);
        lv[6] = $urandom_range(0, 40);
        lv[7] = $urandom_range(40, 127);
        lv[8] = $urandom_range(0, 20);
        lv[9] = $urandom_range(40, 127);
        if (broken) begin
            case ($urandom_range(1, 9))
                1: lv[1] = lv[0];
                2: lv[2] = lv[1];
                3: lv[3] = lv[2];
                4: lv[4] = lv[0];
                5: lv[5] = lv[0];
                6: lv[6] = lv[0];
                7: lv[7] = lv[8];
                8: lv[8] = lv[7];
                default: lv[9] = lv[8];
            endcase
        end
        for (int j = 0; j < 10; j++) pending_samples.push_back(level_sample(lv[j]));
    endtask

    // Pulse-coded bits, two samples each, with an occasional tie
    task automatic add_pulses(input int nbits);
        int hi_lv;
        int lo_lv;
        for (int j = 0; j < nbits; j++) begin
            hi_lv = $urandom_range(30, 127);
            lo_lv = $urandom_range(0, 25);
            if ($urandom_range(0, 15) == 0) lo_lv = hi_lv;
            if ($urandom_range(0, 1)) begin
                pending_samples.push_back(level_sample(hi_lv));
                pending_samples.push_back(level_sample(lo_lv));
            end else begin
                pending_samples.push_back(level_sample(lo_lv));
                pending_samples.push_back(level_sample(hi_lv));
            end
        end
    endtask

    // Period-7 pattern that can hit the preamble twice per period to fill the slots
    task automatic add_burst(input int periods);
        int pat[7];
        pat = '{100, 30, 127, 40, 70, 50, 60};
        for (int p = 0; p < periods; p++) begin
            for (int j = 0; j < 7; j++) pending_samples.push_back(level_sample(pat[j]));
        end
    endtask

    // Drive sample requests and result ready at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pending_samples.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
                    s_payload <= pending_samples.pop_front();
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 13);
        end
    end

    // Predict on accepted samples, check accepted messages
    always @(posedge aclk) begin
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_sample(s_payload);
                samples_taken <= samples_taken + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_msgs.size() == 0) begin
                    flag_mismatch("message with none expected",
                                  64'(m_payload.start_position), '0);
                end else begin
                    want = expected_msgs.pop_front();
                    if (m_payload.bits_first_half !== want.bits_first_half)
                        flag_mismatch("bits_first_half", 64'(m_payload.bits_first_half),
                                      64'(want.bits_first_half));
                    if (m_payload.bits_second_half !== want.bits_second_half)
                        flag_mismatch("bits_second_half", 64'(m_payload.bits_second_half),
                                      64'(want.bits_second_half));
                    if (m_payload.amplitude_sum !== want.amplitude_sum)
                        flag_mismatch("amplitude_sum", 64'(m_payload.amplitude_sum),
                                      64'(want.amplitude_sum));
                    if (m_payload.start_position !== want.start_position)
                        flag_mismatch("start_position", 64'(m_payload.start_position),
                                      64'(want.start_position));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("adsb_preamble_bit_demodulator: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int  pick;
        int  bursts;
        in_t corner[24];
        corner = '{
            '{8'd0, 8'd0},     '{8'd255, 8'd255}, '{8'd0, 8'd255},   '{8'd255, 8'd0},
            '{8'd128, 8'd128}, '{8'd127, 8'd129}, '{8'd129, 8'd127}, '{8'd128, 8'd0},
            '{8'd0, 8'd128},   '{8'd255, 8'd128}, '{8'd128, 8'd255}, '{8'd1, 8'd1},
            '{8'd254, 8'd254}, '{8'd170, 8'd85},  '{8'd85, 8'd170},  '{8'd0, 8'd0},
            '{8'd128, 8'd128}, '{8'd0, 8'd0},     '{8'd128, 8'd128}, '{8'd255, 8'd255},
            '{8'd128, 8'd128}, '{8'd128, 8'd128}, '{8'd0, 8'd255},   '{8'd128, 8'd128}
        };
        for (int s = 0; s < WIN_LEN; s++) pwr_win[s] = '0;
        for (int s = 0; s < MAX_SLOTS; s++) slot_busy[s] = 1'b0;

        // Extremes while the window fills and just after
        for (int j = 0; j < 24; j++) pending_samples.push_back(corner[j]);

        // Shaped traffic: mostly preamble plus bits, some noise and broken preambles
        bursts = 0;
        while (pending_samples.size() < 1700) begin
            pick = $urandom_range(0, 99);
            if ((bursts == 0 && pending_samples.size() > 500) ||
                (bursts == 1 && pending_samples.size() > 1200)) begin
                add_burst(25);
                bursts++;
            end else if (pick < 70) begin
                add_preamble(1'b0);
                add_pulses($urandom_range(8, 60));
            end else if (pick < 85) begin
                repeat ($urandom_range(4, 40))
                    pending_samples.push_back('{SAMPLE_W'($urandom_range(0, 255)),
                                                SAMPLE_W'($urandom_range(0, 255))});
            end else begin
                add_preamble(1'b1);
                add_pulses($urandom_range(4, 30));
            end
        end
        // Flush the slots still open
        add_pulses(120);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Hold until every sample is in, then until every message is out
        while (pending_samples.size() != 0 || s_valid) @(posedge aclk);
        while (expected_msgs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_msgs.size() != 0)
            flag_mismatch("messages never seen", 64'(expected_msgs.size()), '0);

        if (error_count == 0) begin
            $display("adsb_preamble_bit_demodulator: match");
        end else begin
            $display("adsb_preamble_bit_demodulator: mismatch");
        end
        $finish;
    end

endmodule
